// ===== rtl/assert_macros.svh =====
// assertion macros shared by the deframer rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/hfd_pkg.sv =====
// types and constants of the status frame deframer
// no dependencies; used by hfd_cell and haptic_status_frame_deframer
package hfd_pkg;

   localparam int FRAME_BYTES = 16;
   localparam int BYTE_W      = 8;
   localparam int POS_W       = $clog2(FRAME_BYTES);
   // the last byte of a frame is the live input, so one cell fewer than the frame
   localparam int CHAIN_CELLS = FRAME_BYTES - 1;
   localparam int FLAGS_BYTE  = 13;
   localparam int RSP_DATA_W  = 56;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [POS_W-1:0]  pos_type;

   localparam byte_type NIBBLE_OFFSET = 8'h41;
   localparam byte_type END_BYTE      = 8'h3E;
   localparam pos_type  LAST_POS      = pos_type'(FRAME_BYTES - 1);

   // result payload, last field in the lowest bits
   typedef struct packed {
      logic        pad;
      logic [3:0]  grip_buttons;
      logic [2:0]  homing_flags;
      logic [15:0] encoder_c;
      logic [15:0] encoder_b;
      logic [15:0] encoder_a;
   } rsp_data_type;

   // when the final byte arrives, frame byte n sits in this cell of the chain
   function automatic int cell_of(input int frame_byte);
      return FRAME_BYTES - 2 - frame_byte;
   endfunction

endpackage

// ===== rtl/hfd_cell.sv =====
// one byte cell of the frame shift chain
// depends on hfd_pkg
module hfd_cell (
   input  logic             clock,
   input  logic             shift_en,
   input  hfd_pkg::byte_type d_in,
   output hfd_pkg::byte_type q,
   output hfd_pkg::byte_type sym
);
   import hfd_pkg::*;

   byte_type byte_ff;
   byte_type byte_in;

   // take the neighbour's byte on every accepted transfer
   assign byte_in = shift_en ? d_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // symbol value with the link offset removed, modulo 256
   assign q   = byte_ff;
   assign sym = byte_ff - NIBBLE_OFFSET;

endmodule

// ===== rtl/haptic_status_frame_deframer.sv =====
// top level of the status frame deframer: cell chain, position counter, output register
// depends on hfd_pkg, hfd_cell and assert_macros.svh
//
//  channel  | ports        | payload
//  ---------+--------------+-------------------------------------------------------
//  input    | req_t*       | one received link byte per transfer
//  result   | rsp_t*       | encoders a, b, c, homing flags, grip buttons per frame
//
// one byte per cycle unless a held result stalls; the result shows the cycle after the end byte
// the byte chain shifts on each accepted transfer, the decode is a fixed wiring of cells
// reset clears the position counter and the result valid; the chain needs no clearing
// a held result stalls input only while it is not taken (req_tready = free or draining)
module haptic_status_frame_deframer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,  // [7:0] rx_byte
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [hfd_pkg::RSP_DATA_W-1:0] rsp_tdata
   // rsp_tdata: [15:0] encoder_a, [31:16] encoder_b, [47:32] encoder_c,
   //            [50:48] homing_flags, [54:51] grip_buttons, [55] zero
);
   import hfd_pkg::*;

   `include "assert_macros.svh"

   logic         req_xfer;
   logic         frame_done;
   pos_type      pos_ff;
   pos_type      pos_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_data_type rsp_data_ff;
   rsp_data_type rsp_data_in;
   byte_type     cell_d   [CHAIN_CELLS];
   byte_type     cell_q   [CHAIN_CELLS];
   byte_type     cell_sym [CHAIN_CELLS];
   byte_type     last_byte;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign last_byte  = req_tdata;

   // byte chain, newest byte in cell 0
   for (genvar i = 0; i < CHAIN_CELLS; i++) begin : g_chain
      if (i == 0) begin : g_head
         assign cell_d[i] = last_byte;
      end else begin : g_link
         assign cell_d[i] = cell_q[i-1];
      end
      hfd_cell u_cell (
         .clock    (clock),
         .shift_en (req_xfer),
         .d_in     (cell_d[i]),
         .q        (cell_q[i]),
         .sym      (cell_sym[i])
      );
   end

   // position in the frame, wraps after the sixteenth byte either way
   assign frame_done = req_xfer && (pos_ff == LAST_POS);
   assign pos_in     = req_xfer ? pos_ff + pos_type'(1) : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // decode straight from the chain when the closing byte arrives
   always_comb begin
      rsp_data_in     = '0;
      for (int k = 0; k < 4; k++) begin
         rsp_data_in.encoder_a[4*k +: 4] = cell_sym[cell_of(1 + k)][3:0];
         rsp_data_in.encoder_b[4*k +: 4] = cell_sym[cell_of(5 + k)][3:0];
         rsp_data_in.encoder_c[4*k +: 4] = cell_sym[cell_of(9 + k)][3:0];
      end
      rsp_data_in.homing_flags = cell_sym[cell_of(FLAGS_BYTE)][6:4];
      rsp_data_in.grip_buttons = cell_sym[cell_of(FLAGS_BYTE)][3:0];
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (frame_done && (last_byte == END_BYTE)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done && (last_byte == END_BYTE)) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `ASSERT_SAME(a_rsp_from_frame_end, clock, reset, $rose(rsp_valid_ff),
      $past(frame_done) && ($past(last_byte) == END_BYTE))
   `ASSERT_NEXT(a_pos_wraps, clock, reset, frame_done, pos_ff == '0)
   `ASSERT_SAME(a_stall_holds_input, clock, reset, rsp_valid_ff && !rsp_tready,
      !req_tready)

endmodule

// ===== bench/tb_haptic_status_frame_deframer.sv =====
// self-checking bench for the haptic status frame deframer: directed frames, then random link bytes
// depends on hfd_pkg and haptic_status_frame_deframer; decoded frames are checked against a local model
module tb_haptic_status_frame_deframer;
   import hfd_pkg::*;

   localparam byte_type OPEN_BYTE      = 8'h3C;
   localparam int       DIRECTED_BYTES = 6 * FRAME_BYTES;
   localparam int       RANDOM_BYTES   = 2000;
   localparam int       HOLD_CYCLES    = 200;

   // how the closing byte of a directed frame is checked
   typedef enum logic [1:0] {
      ROW_PREDICTED,
      ROW_FRAME,
      ROW_SILENT
   } row_kind_type;

   // one directed frame, byte 0 in the leftmost character
   typedef struct packed {
      logic [127:0] text;
      row_kind_type kind;
      rsp_data_type typed;
   } frame_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // local copy of the deframer state
   byte_type              link_frame [FRAME_BYTES];
   int unsigned           link_pos;
   rsp_data_type          frames_due [$];

   frame_row_type         frame_rows [6];
   int                    bytes_sent;
   int                    mismatches;
   int                    req_idle_pct;
   int                    rsp_idle_pct;
   logic                  hold_request;

   haptic_status_frame_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // store one link byte; returns 1 when it closes a frame with the end byte
   function automatic bit absorb_link_byte(input byte_type b, output rsp_data_type decoded);
      logic [15:0] words [3];
      byte_type    nib_byte;
      byte_type    flags;
      int          w;
      int          n;
      decoded = '0;
      link_frame[link_pos] = b;
      if (link_pos != FRAME_BYTES - 1) begin
         link_pos++;
         return 1'b0;
      end
      link_pos = 0;
      if (b != END_BYTE)
         return 1'b0;
      for (w = 0; w < 3; w++) begin
         for (n = 0; n < 4; n++) begin
            nib_byte = link_frame[1 + 4 * w + n] - NIBBLE_OFFSET;
            words[w][4 * n +: 4] = nib_byte[3:0];
         end
      end
      flags = link_frame[FLAGS_BYTE] - NIBBLE_OFFSET;
      decoded.encoder_a    = words[0];
      decoded.encoder_b    = words[1];
      decoded.encoder_c    = words[2];
      decoded.homing_flags = flags[6:4];
      decoded.grip_buttons = flags[3:0];
      return 1'b1;
   endfunction

   // body byte of a frame: mostly valid nibble codes, some raw bytes, a few early end bytes
   function automatic byte_type frame_body_byte();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 5)
         return END_BYTE;
      if (pick < 30)
         return byte_type'($urandom_range(255));
      return NIBBLE_OFFSET + byte_type'($urandom_range(15));
   endfunction

   // offer one byte from a falling edge, wait for the transfer, update the model
   task automatic push_byte(input byte_type b, input row_kind_type kind = ROW_PREDICTED,
                            input rsp_data_type typed = '0);
      rsp_data_type decoded;
      bit           produced;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      produced = absorb_link_byte(b, decoded);
      case (kind)
         ROW_PREDICTED: if (produced) frames_due.push_back(decoded);
         ROW_FRAME:     frames_due.push_back(typed);
         ROW_SILENT:    ;
         default:       ;
      endcase
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %h got %h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   // stimulus: reset, directed frames, then random frames in three idling phases
   initial begin
      int shape;
      int burst;
      int progress;
      int r;
      int i;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      link_pos     = 0;
      bytes_sent   = 0;
      mismatches   = 0;
      req_idle_pct = 37;
      rsp_idle_pct = 48;
      hold_request = 1'b0;

      // all nibbles zero
      frame_rows[0] = '{text: "<AAAAAAAAAAAAAA>", kind: ROW_FRAME, typed: '0};
      // all nibbles fifteen, grip all pressed, no homing
      frame_rows[1] = '{text: "<PPPPPPPPPPPPPP>", kind: ROW_FRAME,
                        typed: '{pad: 1'b0, grip_buttons: 4'hF, homing_flags: 3'd0,
                                 encoder_c: 16'hFFFF, encoder_b: 16'hFFFF,
                                 encoder_a: 16'hFFFF}};
      // bad start byte, raw byte extremes, early end bytes
      frame_rows[2] = '{text: 128'hFF00_FF00_FF3E_4150_00FF_424F_7AC0_3E3E,
                        kind: ROW_PREDICTED, typed: '0};
      // full frame without end byte, counter wraps silently
      frame_rows[3] = '{text: "<ABCDEFGHIJKLMNZ", kind: ROW_SILENT, typed: '0};
      // runs of early end bytes, frame right after a wrap
      frame_rows[4] = '{text: "<HGFEDCBA>>>>Q>>", kind: ROW_PREDICTED, typed: '0};
      // nibble order, all homing flags, no grip
      frame_rows[5] = '{text: 128'h3C50_4150_4141_5041_5050_5041_41B1_413E, kind: ROW_FRAME,
                        typed: '{pad: 1'b0, grip_buttons: 4'h0, homing_flags: 3'd7,
                                 encoder_c: 16'h00FF, encoder_b: 16'hF0F0,
                                 encoder_a: 16'h0F0F}};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed frames
      for (r = 0; r < 6; r++) begin
         for (i = 0; i < FRAME_BYTES; i++)
            push_byte(frame_rows[r].text[127 - 8 * i -: 8],
                      (i == FRAME_BYTES - 1) ? frame_rows[r].kind : ROW_PREDICTED,
                      frame_rows[r].typed);
      end

      // random frames, mostly well formed
      while (bytes_sent < DIRECTED_BYTES + RANDOM_BYTES) begin
         progress = bytes_sent - DIRECTED_BYTES;
         if (progress < RANDOM_BYTES / 3) begin
            req_idle_pct =  37;
            rsp_idle_pct <= 48;
         end else if (progress < 2 * RANDOM_BYTES / 3) begin
            req_idle_pct =  48;
            rsp_idle_pct <= 37;
         end else begin
            req_idle_pct =  0;
            rsp_idle_pct <= 0;
            hold_request <= 1'b1;
         end
         shape = $urandom_range(99);
         if (shape < 88) begin
            push_byte(($urandom_range(9) == 0) ? byte_type'($urandom_range(255)) : OPEN_BYTE);
            for (i = 1; i < FLAGS_BYTE; i++)
               push_byte(frame_body_byte());
            push_byte($urandom_range(1) ? byte_type'($urandom_range(255))
                                        : NIBBLE_OFFSET + byte_type'($urandom_range(127)));
            push_byte(byte_type'($urandom_range(255)));
            push_byte((shape < 75) ? END_BYTE : byte_type'($urandom_range(255)));
         end else begin
            // noise burst, then filler up to the next frame boundary
            burst = $urandom_range(40, 1);
            repeat (burst) push_byte(byte_type'($urandom_range(255)));
            while (link_pos != 0)
               push_byte(byte_type'($urandom_range(255)));
         end
      end
      req_tvalid <= 1'b0;

      // drain, then a short quiet window for stray results
      while (frames_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // result side ready, random stalls and one long hold-off
   initial begin
      logic hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done  = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // compare every result transfer with the oldest decoded frame
   always @(posedge clock) begin
      rsp_data_type got;
      rsp_data_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_data_type'(rsp_tdata);
         if (frames_due.size() == 0) begin
            $display("%0t: unexpected result, expected none got %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = frames_due.pop_front();
            check_field("encoder_a", want.encoder_a, got.encoder_a);
            check_field("encoder_b", want.encoder_b, got.encoder_b);
            check_field("encoder_c", want.encoder_c, got.encoder_c);
            check_field("homing_flags", want.homing_flags, got.homing_flags);
            check_field("grip_buttons", want.grip_buttons, got.grip_buttons);
         end
      end
   end

   // run limit
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hfd_pkg.sv
rtl/hfd_cell.sv
rtl/haptic_status_frame_deframer.sv
bench/tb_haptic_status_frame_deframer.sv
